[design/cht_pkg.sv]
// Shared widths, codes and control/status types for the canonical Huffman code builder.
package cht_pkg;

    localparam int SYM_W    = 9;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 3;
    localparam int CODE_W   = 16;
    localparam int TIDX_W   = 17;
    localparam int HIST_W   = 10;

    localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNUSED    = 3'd4;

    // result selector for the response register
    localparam logic [2:0] RES_LOAD      = 3'd0;
    localparam logic [2:0] RES_NOT_BUILT = 3'd1;
    localparam logic [2:0] RES_TOO_MANY  = 3'd2;
    localparam logic [2:0] RES_QUERY     = 3'd3;
    localparam logic [2:0] RES_BUILD     = 3'd4;

    typedef struct packed {
        logic       load;
        logic       query;
        logic       build_init;
        logic       comp_step;
        logic       asg_step;
        logic       build_fin;
        logic       res_we;
        logic [2:0] res_sel;
    } t_cmd;

    typedef struct packed {
        logic built;
        logic too_many;
        logic comp_done;
        logic asg_done;
    } t_stat;

endpackage

[design/cht_req_if.sv]
// Request channel: valid/ready handshake with the load/query payload.
interface cht_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [cht_pkg::SYM_W-1:0]   symbol;
    logic [cht_pkg::LEN_W-1:0]   length;
    logic                        last;

    modport source (output valid, output func, output symbol, output length, output last,
                    input ready);
    modport sink   (input valid, input func, input symbol, input length, input last,
                    output ready);
endinterface

[design/cht_rsp_if.sv]
// Response channel: valid/ready handshake with the result payload.
interface cht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cht_pkg::STATUS_W-1:0]  status;
    logic [cht_pkg::CODE_W-1:0]    code;
    logic [cht_pkg::LEN_W-1:0]     code_length;
    logic [cht_pkg::TIDX_W-1:0]    tree_index;

    modport source (output valid, output status, output code, output code_length,
                    output tree_index, input ready);
    modport sink   (input valid, input status, input code, input code_length,
                    input tree_index, output ready);
endinterface

[design/cht_ctrl.sv]
// Controller: request handshake, build sequencing and response valid.
module cht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_func,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  cht_pkg::t_stat i_stat,
    output cht_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QRD   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_COMP  = 3'd3;
    localparam logic [2:0] S_ASG   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_o_valid, n_o_valid;
    logic       w_accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_o_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_o_valid;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_o_valid = r_o_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_func == cht_pkg::FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                        if (i_in_last) begin
                            n_state = S_CHECK;
                        end else begin
                            o_cmd.res_we  = 1'b1;
                            o_cmd.res_sel = cht_pkg::RES_LOAD;
                        end
                    end else if (i_stat.built) begin
                        o_cmd.query = 1'b1;
                        n_state     = S_QRD;
                    end else begin
                        o_cmd.res_we  = 1'b1;
                        o_cmd.res_sel = cht_pkg::RES_NOT_BUILT;
                    end
                end
            end
            S_QRD: begin
                o_cmd.res_we  = 1'b1;
                o_cmd.res_sel = cht_pkg::RES_QUERY;
                n_state       = S_IDLE;
            end
            S_CHECK: begin
                if (i_stat.too_many) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = cht_pkg::RES_TOO_MANY;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.build_init = 1'b1;
                    n_state          = S_COMP;
                end
            end
            S_COMP: begin
                o_cmd.comp_step = 1'b1;
                if (i_stat.comp_done) begin
                    n_state = S_ASG;
                end
            end
            S_ASG: begin
                o_cmd.asg_step = 1'b1;
                if (i_stat.asg_done) begin
                    o_cmd.build_fin = 1'b1;
                    o_cmd.res_we    = 1'b1;
                    o_cmd.res_sel   = cht_pkg::RES_BUILD;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.res_we) begin
            n_o_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

endmodule

[design/cht_datapath.sv]
// Datapath: length/code stores, histogram, first-code computation and code assignment.
module cht_datapath #(
    parameter int MAX_SYMBOLS   = 512,
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cht_pkg::t_cmd                  i_cmd,
    output cht_pkg::t_stat                 o_stat,
    input  logic [cht_pkg::SYM_W-1:0]      i_symbol,
    input  logic [cht_pkg::LEN_W-1:0]      i_length,
    input  logic                           i_last,
    output logic [cht_pkg::STATUS_W-1:0]   o_status,
    output logic [cht_pkg::CODE_W-1:0]     o_code,
    output logic [cht_pkg::LEN_W-1:0]      o_code_length,
    output logic [cht_pkg::TIDX_W-1:0]     o_tree_index
);

    localparam int LEN_W  = cht_pkg::LEN_W;
    localparam int HIST_W = cht_pkg::HIST_W;
    localparam int CODE_W = cht_pkg::CODE_W;
    localparam int TIDX_W = cht_pkg::TIDX_W;
    localparam int SYM_W  = cht_pkg::SYM_W;
    localparam int ADDR_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int CMP_W  = (CNT_W > SYM_W) ? CNT_W : SYM_W;
    localparam int HIDX_W = $clog2(MAX_CODE_BITS + 1);
    // first codes grow by at most one histogram count and a doubling per length
    localparam int RUN_W  = HIST_W + MAX_CODE_BITS + 2;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SYMBOLS);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_BITS);

    // symbol stores
    logic [LEN_W-1:0]  r_len_mem  [0:MAX_SYMBOLS-1];
    logic [CODE_W-1:0] r_code_mem [0:MAX_SYMBOLS-1];
    logic [LEN_W-1:0]  r_rd_len;
    logic [CODE_W-1:0] r_rd_code;

    logic [HIST_W-1:0] r_hist    [0:MAX_CODE_BITS];
    logic [RUN_W-1:0]  r_running [0:MAX_CODE_BITS];
    logic [LEN_W-1:0]  r_largest;
    logic [CNT_W-1:0]  r_count;
    logic              r_built;
    logic              r_closed;

    logic [LEN_W-1:0]  r_bits;
    logic [RUN_W-1:0]  r_code;
    logic [CNT_W-1:0]  r_ridx;
    logic [ADDR_W-1:0] r_widx;
    logic              r_pv;
    logic              r_ovf;
    logic              r_q_hit;

    logic [LEN_W-1:0]  w_len_sat;
    logic [HIDX_W-1:0] w_len_idx;
    logic [ADDR_W-1:0] w_sym_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_sym_ok;
    logic [CMP_W-1:0]  w_sym_ext;
    logic [CNT_W-1:0]  w_cnt_base;
    logic [LEN_W-1:0]  w_lrg_base;
    logic [HIST_W-1:0] w_prev;
    logic [RUN_W-1:0]  w_code_next;
    logic [HIDX_W-1:0] w_rlen_idx;
    logic [RUN_W-1:0]  w_run_cur;
    logic              w_run_ovf;
    logic              w_comp_done;

    assign w_len_sat  = (i_length > LEN_MAX) ? LEN_MAX : i_length;
    assign w_len_idx  = w_len_sat[HIDX_W-1:0];
    assign w_sym_addr = ADDR_W'(i_symbol);
    assign w_sym_ext  = CMP_W'(i_symbol);
    assign w_sym_ok   = w_sym_ext < CMP_W'(MAX_SYMBOLS);
    assign w_rd_addr  = i_cmd.asg_step ? r_ridx[ADDR_W-1:0] : w_sym_addr;

    // a load after the load marked last opens a new set
    assign w_cnt_base = r_closed ? '0 : r_count;
    assign w_lrg_base = r_closed ? '0 : r_largest;

    assign w_comp_done = r_bits > r_largest;
    assign w_prev      = (r_bits == LEN_W'(1)) ? '0 : r_hist[HIDX_W'(r_bits - LEN_W'(1))];
    assign w_code_next = (r_code + RUN_W'(w_prev)) << 1;

    assign w_rlen_idx = HIDX_W'(r_rd_len);
    assign w_run_cur  = r_running[w_rlen_idx];
    assign w_run_ovf  = (w_run_cur >> r_rd_len) != '0;

    assign o_stat.built     = r_built;
    assign o_stat.too_many  = r_count >= CNT_MAX;
    assign o_stat.comp_done = w_comp_done;
    assign o_stat.asg_done  = (r_ridx == r_count) && !r_pv;

    // length store: written by loads, read by queries and the assignment pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_sym_ok) begin
            r_len_mem[w_sym_addr] <= w_len_sat;
        end
        r_rd_len <= r_len_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_code_mem[r_widx] <= (r_rd_len == '0) ? '0 : w_run_cur[CODE_W-1:0];
        end
        r_rd_code <= r_code_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAX_CODE_BITS; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_cmd.load) begin
            for (int k = 0; k <= MAX_CODE_BITS; k++) begin
                if (r_closed) begin
                    r_hist[k] <= (HIDX_W'(k) == w_len_idx) ? HIST_W'(1) : '0;
                end else if (HIDX_W'(k) == w_len_idx && r_hist[k] != cht_pkg::HIST_MAX) begin
                    r_hist[k] <= r_hist[k] + HIST_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest <= '0;
            r_count   <= '0;
            r_built   <= 1'b0;
            r_closed  <= 1'b0;
        end else if (i_cmd.load) begin
            r_largest <= (w_len_sat > w_lrg_base) ? w_len_sat : w_lrg_base;
            r_count   <= (w_cnt_base < CNT_MAX) ? w_cnt_base + CNT_W'(1) : w_cnt_base;
            r_built   <= 1'b0;
            r_closed  <= i_last;
        end else if (i_cmd.build_fin) begin
            r_built <= !r_ovf;
        end
    end

    // per-length running code: first codes, then incremented as symbols take them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.build_init) begin
            for (int k = 0; k <= MAX_CODE_BITS; k++) begin
                r_running[k] <= '0;
            end
        end else if (i_cmd.comp_step && !w_comp_done) begin
            r_running[HIDX_W'(r_bits)] <= w_code_next;
        end else if (r_pv && r_rd_len != '0) begin
            r_running[w_rlen_idx] <= w_run_cur + RUN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_code <= '0;
        end else if (i_cmd.comp_step && !w_comp_done) begin
            r_code <= w_code_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_ridx <= '0;
            r_pv   <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.build_init) begin
            r_bits <= LEN_W'(1);
            r_ridx <= '0;
            r_pv   <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cmd.comp_step && !w_comp_done) begin
                r_bits <= r_bits + LEN_W'(1);
            end
            if (i_cmd.asg_step && r_ridx != r_count) begin
                r_ridx <= r_ridx + CNT_W'(1);
                r_pv   <= 1'b1;
            end else begin
                r_pv <= 1'b0;
            end
            if (r_pv && r_rd_len != '0 && w_run_ovf) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // write address is the read index registered, so it trails the read
    always_ff @(posedge i_clk) begin
        r_widx <= r_ridx[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_q_hit <= w_sym_ok && (w_sym_ext < CMP_W'(r_count));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            o_code        <= '0;
            o_code_length <= '0;
            o_tree_index  <= '0;
            unique case (i_cmd.res_sel)
                cht_pkg::RES_LOAD:      o_status <= cht_pkg::ST_OK;
                cht_pkg::RES_NOT_BUILT: o_status <= cht_pkg::ST_NOT_BUILT;
                cht_pkg::RES_TOO_MANY:  o_status <= cht_pkg::ST_TOO_MANY;
                cht_pkg::RES_BUILD: begin
                    o_status <= r_ovf ? cht_pkg::ST_OVERFLOW : cht_pkg::ST_OK;
                end
                cht_pkg::RES_QUERY: begin
                    if (!r_q_hit || r_rd_len == '0) begin
                        o_status <= cht_pkg::ST_UNUSED;
                    end else begin
                        o_status      <= cht_pkg::ST_OK;
                        o_code        <= r_rd_code;
                        o_code_length <= r_rd_len;
                        o_tree_index  <= (TIDX_W'(1) << r_rd_len) + TIDX_W'(r_rd_code);
                    end
                end
                default: o_status <= cht_pkg::ST_OK;
            endcase
        end
    end

endmodule

[design/canonical_huffman_code_builder_core.sv]
// Canonical Huffman code builder: takes one code length per symbol (tagged with the
// symbol number), and on the load marked last assigns deflate-style canonical codes;
// queries then return a symbol's code, length and heap tree index. One request is in
// work at a time. A query does one registered read of the symbol stores. The build
// on the last load runs one first-code step per length up to L, the largest length in
// the set, then assigns one symbol per cycle through the single read port of the
// length store for each of the N loads in the set; a set with too many symbols ends
// without a build. The symbol stores have no clearing pass.
module canonical_huffman_code_builder_core #(
    parameter int MAX_SYMBOLS   = 512,
    parameter int MAX_CODE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp
);

    cht_pkg::t_cmd  w_cmd;
    cht_pkg::t_stat w_stat;

    cht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_func   (i_req.func),
        .i_in_last   (i_req.last),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cht_datapath #(
        .MAX_SYMBOLS   (MAX_SYMBOLS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_symbol      (i_req.symbol),
        .i_length      (i_req.length),
        .i_last        (i_req.last),
        .o_status      (o_rsp.status),
        .o_code        (o_rsp.code),
        .o_code_length (o_rsp.code_length),
        .o_tree_index  (o_rsp.tree_index)
    );

endmodule

[tb/tb_canonical_huffman_code_builder_core.sv]
// Self-checking testbench for the canonical Huffman code builder: length loads, code builds, queries.
`timescale 1ns / 100ps

module tb_canonical_huffman_code_builder_core;

    localparam int MAX_SYM        = 512;
    localparam int MAX_BITS       = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic                      func;
        logic [cht_pkg::SYM_W-1:0] symbol;
        logic [cht_pkg::LEN_W-1:0] length;
        logic                      last;
    } t_huff_req;

    typedef struct packed {
        logic [cht_pkg::STATUS_W-1:0] status;
        logic [cht_pkg::CODE_W-1:0]   code;
        logic [cht_pkg::LEN_W-1:0]    code_length;
        logic [cht_pkg::TIDX_W-1:0]   tree_index;
    } t_huff_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cht_req_if req_bus ();
    cht_rsp_if rsp_bus ();

    canonical_huffman_code_builder_core #(
        .MAX_SYMBOLS   (MAX_SYM),
        .MAX_CODE_BITS (MAX_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow state of the code builder
    logic [cht_pkg::LEN_W-1:0]  len_mem  [MAX_SYM];
    logic [cht_pkg::CODE_W-1:0] code_mem [MAX_SYM];
    int unsigned       len_hist [MAX_BITS+1];
    int unsigned       max_len_seen;
    int unsigned       load_count;
    bit                codes_built;
    bit                set_closed;

    t_huff_req   req_queue[$];
    t_huff_rsp   expected_rsp[$];
    int unsigned queued_items;
    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned sender_idle_pct;
    int unsigned rsp_stall_pct;
    int unsigned hold_left;
    logic        req_taken;

    function automatic logic [cht_pkg::STATUS_W-1:0] build_codes();
        int unsigned first_free [MAX_BITS+1];
        int unsigned c;
        int unsigned l;
        bit          ovf;
        set_closed  = 1'b1;
        codes_built = 1'b0;
        if (load_count >= MAX_SYM)
            return cht_pkg::ST_TOO_MANY;
        c   = 0;
        ovf = 1'b0;
        for (int b = 0; b <= MAX_BITS; b++)
            first_free[b] = 0;
        for (int b = 1; b <= MAX_BITS && b <= max_len_seen; b++) begin
            c = (c + ((b == 1) ? 0 : len_hist[b-1])) << 1;
            first_free[b] = c;
        end
        for (int i = 0; i < load_count && i < MAX_SYM; i++) begin
            l = len_mem[i];
            if (l == 0) begin
                code_mem[i] = '0;
            end else begin
                if (first_free[l] >= (32'd1 << l))
                    ovf = 1'b1;
                code_mem[i]   = cht_pkg::CODE_W'(first_free[l]);
                first_free[l] = first_free[l] + 1;
            end
        end
        if (ovf)
            return cht_pkg::ST_OVERFLOW;
        codes_built = 1'b1;
        return cht_pkg::ST_OK;
    endfunction

    function automatic t_huff_rsp huff_predict(t_huff_req r);
        t_huff_rsp   res;
        int unsigned l;
        res = '0;
        if (r.func == cht_pkg::FUNC_LOAD) begin
            if (set_closed) begin
                for (int b = 0; b <= MAX_BITS; b++)
                    len_hist[b] = 0;
                max_len_seen = 0;
                load_count   = 0;
                codes_built  = 1'b0;
                set_closed   = 1'b0;
            end
            l = (r.length > MAX_BITS) ? MAX_BITS : r.length;
            if (r.symbol < MAX_SYM)
                len_mem[r.symbol] = cht_pkg::LEN_W'(l);
            if (len_hist[l] < cht_pkg::HIST_MAX)
                len_hist[l]++;
            if (l > max_len_seen)
                max_len_seen = l;
            if (load_count < MAX_SYM)
                load_count++;
            res.status = r.last ? build_codes() : cht_pkg::ST_OK;
        end else if (!codes_built) begin
            res.status = cht_pkg::ST_NOT_BUILT;
        end else if (r.symbol >= MAX_SYM || r.symbol >= load_count || len_mem[r.symbol] == 0) begin
            res.status = cht_pkg::ST_UNUSED;
        end else begin
            l = (len_mem[r.symbol] > MAX_BITS) ? MAX_BITS : len_mem[r.symbol];
            res.status      = cht_pkg::ST_OK;
            res.code        = code_mem[r.symbol];
            res.code_length = cht_pkg::LEN_W'(l);
            res.tree_index  = (cht_pkg::TIDX_W'(1) << l) + cht_pkg::TIDX_W'(code_mem[r.symbol]);
        end
        return res;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_taken) begin
            if (req_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                req_bus.func   <= req_queue[0].func;
                req_bus.symbol <= req_queue[0].symbol;
                req_bus.length <= req_queue[0].length;
                req_bus.last   <= req_queue[0].last;
                req_bus.valid  <= 1'b1;
                void'(req_queue.pop_front());
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // monitor: predict on each accepted request, check each accepted response
    always @(posedge i_clk) begin
        t_huff_rsp got;
        t_huff_rsp want;
        bit        req_fire;
        bit        rsp_fire;
        if (!i_rst_n) begin
            req_taken   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            req_fire = req_bus.valid && req_bus.ready;
            rsp_fire = rsp_bus.valid && rsp_bus.ready;
            req_taken <= req_fire;
            if (req_fire)
                expected_rsp.push_back(huff_predict({req_bus.func, req_bus.symbol,
                                                     req_bus.length, req_bus.last}));
            if (rsp_fire) begin
                got = {rsp_bus.status, rsp_bus.code, rsp_bus.code_length, rsp_bus.tree_index};
                if (expected_rsp.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected response status=%0d code=%h len=%0d idx=%h",
                             $time, got.status, got.code, got.code_length, got.tree_index);
                end else begin
                    want = expected_rsp.pop_front();
                    if (got.status !== want.status || got.code !== want.code ||
                        got.code_length !== want.code_length ||
                        got.tree_index !== want.tree_index) begin
                        mismatches++;
                        $display("%0t: mismatch expected status=%0d code=%h len=%0d idx=%h",
                                 $time, want.status, want.code, want.code_length,
                                 want.tree_index);
                        $display("%0t:          actual   status=%0d code=%h len=%0d idx=%h",
                                 $time, got.status, got.code, got.code_length, got.tree_index);
                    end
                end
            end
            if (req_fire || rsp_fire ||
                (req_queue.size() == 0 && expected_rsp.size() == 0 && !req_bus.valid))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_load(int unsigned sym, int unsigned len, bit fin);
        t_huff_req r;
        r.func   = cht_pkg::FUNC_LOAD;
        r.symbol = cht_pkg::SYM_W'(sym);
        r.length = cht_pkg::LEN_W'(len);
        r.last   = fin;
        req_queue.push_back(r);
        queued_items++;
    endtask

    // length and last are don't-care on a query, so they get noise
    task automatic push_query(int unsigned sym);
        t_huff_req r;
        r.func   = cht_pkg::FUNC_QUERY;
        r.symbol = cht_pkg::SYM_W'(sym);
        r.length = cht_pkg::LEN_W'($urandom_range(0, 31));
        r.last   = 1'($urandom_range(0, 1));
        req_queue.push_back(r);
        queued_items++;
    endtask

    // writes every length entry at least once, overruns the symbol count
    task automatic queue_fill_set();
        for (int s = 0; s < MAX_SYM; s++)
            push_load(s, $urandom_range(0, 31), 1'b0);
        for (int j = 0; j < 8; j++)
            push_load($urandom_range(0, MAX_SYM-1), $urandom_range(0, 31), j == 7);
        push_query(5);
    endtask

    task automatic queue_directed();
        // small mixed set, with a query while the set is still open
        push_load(0, 2, 1'b0);
        push_query(0);
        push_load(1, 1, 1'b0);
        push_load(2, 3, 1'b0);
        push_load(3, 3, 1'b1);
        for (int s = 0; s <= 4; s++)
            push_query(s);
        // longest length, oversized length saturating, unused symbol
        push_load(0, 16, 1'b0);
        push_load(1, 31, 1'b0);
        push_load(2, 0, 1'b1);
        push_query(0);
        push_query(1);
        push_query(2);
        // three one-bit codes cannot fit
        push_load(0, 1, 1'b0);
        push_load(1, 1, 1'b0);
        push_load(2, 1, 1'b1);
        push_query(0);
        // set of one unused symbol
        push_load(0, 0, 1'b1);
        push_query(0);
        push_query(MAX_SYM-1);
    endtask

    // prefix-free length set from random leaf splits, loaded in random order
    task automatic gen_good_set();
        int unsigned leaves[$];
        int unsigned order[$];
        int unsigned k;
        int unsigned idx;
        int unsigned tmp;
        int unsigned n;
        int unsigned j;
        k = $urandom_range(1, 24);
        if (k == 1) begin
            leaves.push_back($urandom_range(1, MAX_BITS));
        end else begin
            leaves.push_back(1);
            leaves.push_back(1);
            while (leaves.size() < k) begin
                idx = $urandom_range(0, 1) ? leaves.size() - 1
                                           : $urandom_range(0, leaves.size() - 1);
                if (leaves[idx] < MAX_BITS) begin
                    tmp = leaves[idx];
                    leaves.delete(idx);
                    leaves.push_back(tmp + 1);
                    leaves.push_back(tmp + 1);
                end
            end
            if ($urandom_range(0, 3) == 0)
                void'(leaves.pop_back());   // incomplete code
        end
        repeat ($urandom_range(0, 4))
            leaves.push_back(0);
        n = leaves.size();
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = leaves[i];
            leaves[i] = leaves[j];
            leaves[j] = tmp;
        end
        for (int i = 0; i < n; i++)
            order.push_back(i);
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < n; i++)
            push_load(order[i], leaves[order[i]], i == n - 1);
        repeat ($urandom_range(3, 12))
            push_query(($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_SYM-1)
                                                    : $urandom_range(0, n));
    endtask

    // arbitrary lengths and symbols, sometimes left open
    task automatic gen_broken_set();
        int unsigned m;
        m = $urandom_range(1, 10);
        for (int j = 0; j < m; j++)
            push_load($urandom_range(0, 1) ? j : $urandom_range(0, MAX_SYM-1),
                      $urandom_range(0, 31), (j == m - 1) && ($urandom_range(0, 3) != 0));
        repeat ($urandom_range(1, 4))
            push_query($urandom_range(0, 11));
    endtask

    task automatic wait_idle();
        while (req_queue.size() != 0 || expected_rsp.size() != 0 || req_bus.valid)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int unsigned n_items, int unsigned idle_pct, int unsigned stall,
                             int unsigned hold);
        int unsigned target;
        int unsigned pick;
        wait_idle();
        sender_idle_pct = idle_pct;
        rsp_stall_pct   = stall;
        hold_left       = hold;
        target          = queued_items + n_items;
        while (queued_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                gen_good_set();
            else if (pick < 90)
                gen_broken_set();
            else
                repeat ($urandom_range(1, 3))
                    push_query($urandom_range(0, MAX_SYM-1));
        end
    endtask

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.func    = cht_pkg::FUNC_LOAD;
        req_bus.symbol  = '0;
        req_bus.length  = '0;
        req_bus.last    = 1'b0;
        rsp_bus.ready   = 1'b0;
        sender_idle_pct = 0;
        rsp_stall_pct   = 0;
        hold_left       = 0;
        queued_items    = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        for (int b = 0; b <= MAX_BITS; b++)
            len_hist[b] = 0;
        for (int s = 0; s < MAX_SYM; s++) begin
            len_mem[s]  = '0;
            code_mem[s] = '0;
        end
        max_len_seen = 0;
        load_count   = 0;
        codes_built  = 1'b0;
        set_closed   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_fill_set();
        queue_directed();
        run_phase(15, 0, 0, 0);
        run_phase(15, 85, 0, 0);
        // long receiver hold-off while requests keep coming
        run_phase(15, 0, 85, 300);
        run_phase(15, 10, 10, 0);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
design/cht_pkg.sv
design/cht_req_if.sv
design/cht_rsp_if.sv
design/cht_ctrl.sv
design/cht_datapath.sv
design/canonical_huffman_code_builder_core.sv
tb/tb_canonical_huffman_code_builder_core.sv
